// ===== hdl/b64d_pkg.sv =====
// Shared types and character constants for the streaming Base64 decoder.
package b64d_pkg;

  localparam int unsigned MaxResults = 3;

  // Character codes of the standard alphabet and its delimiters
  localparam logic [7:0] CharUpA    = 8'h41;  // 'A'
  localparam logic [7:0] CharUpZ    = 8'h5A;  // 'Z'
  localparam logic [7:0] CharLowA   = 8'h61;  // 'a'
  localparam logic [7:0] CharLowZ   = 8'h7A;  // 'z'
  localparam logic [7:0] CharZero   = 8'h30;  // '0'
  localparam logic [7:0] CharNine   = 8'h39;  // '9'
  localparam logic [7:0] CharPlus   = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash  = 8'h2F;  // '/'
  localparam logic [7:0] CharPad    = 8'h3D;  // '='
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  localparam logic [7:0] LowerOffset = 8'd26;
  localparam logic [7:0] DigitOffset = 8'd52;
  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;

  typedef logic [1:0] b64d_cnt_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       end_of_string;
    logic       bad_char;
  } b64d_out_t;

  // Classified input character
  typedef struct packed {
    logic       blank;
    logic       alpha;
    logic [5:0] value;
  } b64d_sym_t;

  // Results produced by one input transaction, res[0] leaves first
  typedef struct packed {
    b64d_cnt_t                     count;
    b64d_out_t [MaxResults-1:0]    res;
  } b64d_set_t;

endpackage

// ===== hdl/b64d_sextet_map.sv =====
// Character classifier: alphabet lookup to a 6-bit sextet, whitespace detect.
module b64d_sextet_map import b64d_pkg::*; (
  input  logic [7:0] char_i,
  output b64d_sym_t  sym_o
);

  logic [7:0] diff;

  always_comb begin
    sym_o = '0;
    diff  = '0;
    if (char_i >= CharUpA && char_i <= CharUpZ) begin
      diff        = char_i - CharUpA;
      sym_o.alpha = 1'b1;
      sym_o.value = diff[5:0];
    end else if (char_i >= CharLowA && char_i <= CharLowZ) begin
      diff        = char_i - CharLowA + LowerOffset;
      sym_o.alpha = 1'b1;
      sym_o.value = diff[5:0];
    end else if (char_i >= CharZero && char_i <= CharNine) begin
      diff        = char_i - CharZero + DigitOffset;
      sym_o.alpha = 1'b1;
      sym_o.value = diff[5:0];
    end else if (char_i == CharPlus) begin
      sym_o.alpha = 1'b1;
      sym_o.value = SextetPlus;
    end else if (char_i == CharSlash) begin
      sym_o.alpha = 1'b1;
      sym_o.value = SextetSlash;
    end
    sym_o.blank = (char_i == CharSpace) || (char_i >= CharTab && char_i <= CharCr);
  end

endmodule

// ===== hdl/b64d_core.sv =====
// Input register, sextet group state and per-character result generation.
module b64d_core import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  b64d_in_t  in_data_i,
  input  logic      buf_free_i,
  output logic      set_load_o,
  output b64d_set_t set_o
);

  logic      in_valid_q;
  b64d_in_t  in_q;
  logic [17:0] grp_q, grp_d;
  b64d_cnt_t   cnt_q, cnt_d;
  logic        stopped_q, stopped_d;
  logic        inv_q, inv_d;

  b64d_sym_t   sym;
  logic        active;
  logic        full;
  logic        bad;
  logic        move;
  logic [23:0] word;

  b64d_sextet_map u_map (
    .char_i (in_q.char_in),
    .sym_o  (sym)
  );

  always_comb begin
    grp_d     = grp_q;
    cnt_d     = cnt_q;
    stopped_d = stopped_q;
    inv_d     = inv_q;
    set_o     = '0;
    full      = 1'b0;
    bad       = 1'b0;
    word      = {grp_q, sym.value};
    active    = !stopped_q && !sym.blank;

    if (active) begin
      if (!sym.alpha) begin
        stopped_d = 1'b1;
        inv_d     = (in_q.char_in != CharPad);
      end else if (cnt_q == 2'd3) begin
        full         = 1'b1;
        set_o.count  = 2'd3;
        set_o.res[0] = '{byte_out: word[23:16], byte_valid: 1'b1,
                         end_of_string: 1'b0, bad_char: 1'b0};
        set_o.res[1] = '{byte_out: word[15:8], byte_valid: 1'b1,
                         end_of_string: 1'b0, bad_char: 1'b0};
        set_o.res[2] = '{byte_out: word[7:0], byte_valid: 1'b1,
                         end_of_string: 1'b0, bad_char: 1'b0};
        grp_d        = '0;
        cnt_d        = '0;
      end else begin
        grp_d = {grp_q[11:0], sym.value};
        cnt_d = cnt_q + 2'd1;
      end
    end

    if (in_q.last_char) begin
      // tail of a partial group: k sextets give k-1 bytes
      bad = stopped_d && inv_d && (cnt_d != 2'd0);
      case (cnt_d)
        2'd2: begin
          set_o.count  = 2'd1;
          set_o.res[0] = '{byte_out: grp_d[11:4], byte_valid: 1'b1,
                           end_of_string: 1'b1, bad_char: bad};
        end
        2'd3: begin
          set_o.count  = 2'd2;
          set_o.res[0] = '{byte_out: grp_d[17:10], byte_valid: 1'b1,
                           end_of_string: 1'b0, bad_char: 1'b0};
          set_o.res[1] = '{byte_out: grp_d[9:2], byte_valid: 1'b1,
                           end_of_string: 1'b1, bad_char: bad};
        end
        default: begin
          if (full) begin
            set_o.res[2].end_of_string = 1'b1;
          end else begin
            set_o.count  = 2'd1;
            set_o.res[0] = '{byte_out: 8'h00, byte_valid: 1'b0,
                             end_of_string: 1'b1, bad_char: bad};
          end
        end
      endcase
      grp_d     = '0;
      cnt_d     = '0;
      stopped_d = 1'b0;
      inv_d     = 1'b0;
    end
  end

  // zero-result characters never wait on the output buffer
  assign move       = in_valid_q && ((set_o.count == 2'd0) || buf_free_i);
  assign set_load_o = in_valid_q && (set_o.count != 2'd0) && buf_free_i;
  assign in_ready_o = !in_valid_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      grp_q      <= '0;
      cnt_q      <= '0;
      stopped_q  <= 1'b0;
      inv_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (move) begin
        grp_q     <= grp_d;
        cnt_q     <= cnt_d;
        stopped_q <= stopped_d;
        inv_q     <= inv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

endmodule

// ===== hdl/b64d_out_buf.sv =====
// Result buffer: up to three results, shifted out one per cycle when ready.
module b64d_out_buf import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  b64d_set_t set_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output b64d_out_t out_data_o
);

  b64d_out_t [MaxResults-1:0] ent_q;
  b64d_cnt_t                  rem_q;
  logic                       pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (rem_q == 2'd0) || ((rem_q == 2'd1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= set_i.count;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= set_i.res;
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
      ent_q[1] <= ent_q[2];
    end
  end

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// Streaming Base64 decoder top level: one character in, up to three bytes out.
// A character is registered and decoded from the input register; its results
//   load into the output buffer register once the buffer is free, then leave.
// Throughput: one character per cycle; results drain one per cycle while
//   out_ready_i is high, and a character with results stalls until they drain.
// Reset: rst_ni clears the group state, valid flags and buffer count.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  b64d_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output b64d_out_t out_data_o
);

  // Result set handed from the decode stage to the output buffer
  b64d_set_t set;
  logic      set_load;
  logic      buf_free;

  // Decode stage: input register, sextet packing, tail handling at end
  b64d_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .buf_free_i (buf_free),
    .set_load_o (set_load),
    .set_o      (set)
  );

  // Output stage: buffers one transaction's results, drains in order
  b64d_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (set_load),
    .set_i       (set),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
